// File: hdl/hapsch_pkg.sv
package hapsch_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;
  localparam int unsigned MaskW = 8;
  localparam int unsigned CntW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_ON  = 3'd0,
    CFG_PULSE_GAP = 3'd1,
    CFG_MERGE_WIN = 3'd2,
    CFG_QUIET     = 3'd3,
    CFG_ERR_MASK  = 3'd4,
    CFG_ACT_MASK  = 3'd5
  } cfg_idx_t;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_IDLE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } event_t;

  localparam logic [DurW-1:0]  PulseOnRst  = 16'd60;
  localparam logic [DurW-1:0]  PulseGapRst = 16'd90;
  localparam logic [DurW-1:0]  MergeWinRst = 16'd150;
  localparam logic [DurW-1:0]  QuietRst    = 16'd1000;
  localparam logic [MaskW-1:0] ErrMaskRst  = 8'h01;
  localparam logic [MaskW-1:0] ActMaskRst  = 8'h02;

  // Pulse counts left after the first pulse of a train has begun.
  localparam logic [CntW-1:0] LeftAfterErr   = 2'd2;
  localparam logic [CntW-1:0] LeftAfterAct   = 2'd1;
  localparam logic [CntW-1:0] LeftAfterOther = 2'd0;

endpackage

// File: hdl/haptic_alert_pulse_scheduler_core.sv
// A poll is held in the input register, then its result in the result register; the
// scheduler state updates as the poll moves from the one register to the other.
// Throughput: one poll per cycle while out_ready holds; the scheduler update is
// a single pass of 32-bit subtract/compare and add logic between the two registers.
// Reset (rst_n low, synchronous): all scheduler state is cleared, both
// pipeline registers are emptied and the configuration registers take their defaults.
module haptic_alert_pulse_scheduler_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hapsch_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [hapsch_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [hapsch_pkg::TimeW-1:0]       in_now_ms,
  input  logic [hapsch_pkg::MaskW-1:0]       in_notify_bits,
  input  logic                               in_enable,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_event_res
);

  // Configuration registers.
  logic [hapsch_pkg::DurW-1:0]  pulse_on_r, pulse_gap_r, merge_win_r, quiet_r;
  logic [hapsch_pkg::MaskW-1:0] err_mask_r, act_mask_r;

  // Input register.
  logic                         iv_r;
  logic [hapsch_pkg::TimeW-1:0] now_r;
  logic [hapsch_pkg::MaskW-1:0] bits_r;
  logic                         en_r;

  // Result register.
  logic                ov_r;
  hapsch_pkg::event_t  ev_r, ev_nxt;

  // Scheduler state.
  logic                         train_r, train_nxt;
  logic                         motor_r, motor_nxt;
  logic                         merging_r, merging_nxt;
  logic                         cool_r, cool_nxt;
  logic [hapsch_pkg::MaskW-1:0] pend_r, pend_nxt;
  logic [hapsch_pkg::CntW-1:0]  left_r, left_nxt;
  logic [hapsch_pkg::TimeW-1:0] dl_r, dl_nxt;
  logic [hapsch_pkg::TimeW-1:0] qend_r, qend_nxt;

  logic                         advance;
  logic [hapsch_pkg::TimeW-1:0] dl_diff, q_diff;
  logic                         dl_wait, q_wait;
  logic [hapsch_pkg::TimeW-1:0] t_on, t_gap, t_merge, t_quiet;
  logic [hapsch_pkg::MaskW-1:0] merged;

  assign advance  = iv_r && (!ov_r || out_ready);
  assign in_ready = !iv_r || advance;

  assign out_valid     = ov_r;
  assign out_event_res = ev_r;

  // A deadline has passed once the wrapped difference is non-negative.
  assign dl_diff = now_r - dl_r;
  assign q_diff  = now_r - qend_r;
  assign dl_wait = dl_diff[hapsch_pkg::TimeW-1];
  assign q_wait  = q_diff[hapsch_pkg::TimeW-1];

  assign t_on    = now_r + {{(hapsch_pkg::TimeW-hapsch_pkg::DurW){1'b0}}, pulse_on_r};
  assign t_gap   = now_r + {{(hapsch_pkg::TimeW-hapsch_pkg::DurW){1'b0}}, pulse_gap_r};
  assign t_merge = now_r + {{(hapsch_pkg::TimeW-hapsch_pkg::DurW){1'b0}}, merge_win_r};
  assign t_quiet = now_r + {{(hapsch_pkg::TimeW-hapsch_pkg::DurW){1'b0}}, quiet_r};
  assign merged  = pend_r | bits_r;

  always_comb begin
    train_nxt   = train_r;
    motor_nxt   = motor_r;
    merging_nxt = merging_r;
    cool_nxt    = cool_r;
    pend_nxt    = pend_r;
    left_nxt    = left_r;
    dl_nxt      = dl_r;
    qend_nxt    = qend_r;
    ev_nxt      = hapsch_pkg::EV_IDLE;

    if (!en_r) begin
      // Abort: silence the motor and start a cooldown if a train was running.
      if (train_r) begin
        qend_nxt = t_quiet;
        cool_nxt = 1'b1;
      end
      train_nxt   = 1'b0;
      motor_nxt   = 1'b0;
      merging_nxt = 1'b0;
      pend_nxt    = '0;
      left_nxt    = '0;
      ev_nxt      = motor_r ? hapsch_pkg::EV_STOP : hapsch_pkg::EV_IDLE;
    end else if (train_r) begin
      if (!dl_wait) begin
        if (motor_r) begin
          motor_nxt = 1'b0;
          dl_nxt    = t_gap;
          if (left_r == '0) begin
            train_nxt = 1'b0;
            cool_nxt  = 1'b1;
            qend_nxt  = t_quiet;
          end
          ev_nxt = hapsch_pkg::EV_STOP;
        end else begin
          left_nxt  = left_r - 1'b1;
          motor_nxt = 1'b1;
          dl_nxt    = t_on;
          ev_nxt    = hapsch_pkg::EV_START;
        end
      end
    end else if (!cool_r || !q_wait) begin
      cool_nxt = 1'b0;
      pend_nxt = merged;
      if (merged != '0) begin
        if (!merging_r) begin
          merging_nxt = 1'b1;
          dl_nxt      = t_merge;
        end else if (!dl_wait) begin
          // Window closed: the first pulse of the train begins at once.
          merging_nxt = 1'b0;
          priority if ((merged & err_mask_r) != '0) begin
            left_nxt = hapsch_pkg::LeftAfterErr;
          end else if ((merged & act_mask_r) != '0) begin
            left_nxt = hapsch_pkg::LeftAfterAct;
          end else begin
            left_nxt = hapsch_pkg::LeftAfterOther;
          end
          pend_nxt  = '0;
          train_nxt = 1'b1;
          motor_nxt = 1'b1;
          dl_nxt    = t_on;
          ev_nxt    = hapsch_pkg::EV_START;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_on_r  <= hapsch_pkg::PulseOnRst;
      pulse_gap_r <= hapsch_pkg::PulseGapRst;
      merge_win_r <= hapsch_pkg::MergeWinRst;
      quiet_r     <= hapsch_pkg::QuietRst;
      err_mask_r  <= hapsch_pkg::ErrMaskRst;
      act_mask_r  <= hapsch_pkg::ActMaskRst;
    end else if (cfg_we) begin
      case (cfg_index)
        hapsch_pkg::CFG_PULSE_ON:  pulse_on_r  <= cfg_data;
        hapsch_pkg::CFG_PULSE_GAP: pulse_gap_r <= cfg_data;
        hapsch_pkg::CFG_MERGE_WIN: merge_win_r <= cfg_data;
        hapsch_pkg::CFG_QUIET:     quiet_r     <= cfg_data;
        hapsch_pkg::CFG_ERR_MASK:  err_mask_r  <= cfg_data[hapsch_pkg::MaskW-1:0];
        hapsch_pkg::CFG_ACT_MASK:  act_mask_r  <= cfg_data[hapsch_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r      <= 1'b0;
      ov_r      <= 1'b0;
      ev_r      <= hapsch_pkg::EV_IDLE;
      train_r   <= 1'b0;
      motor_r   <= 1'b0;
      merging_r <= 1'b0;
      cool_r    <= 1'b0;
      pend_r    <= '0;
      left_r    <= '0;
      dl_r      <= '0;
      qend_r    <= '0;
    end else begin
      if (in_ready) begin
        iv_r <= in_valid;
      end
      if (advance) begin
        ov_r      <= 1'b1;
        ev_r      <= ev_nxt;
        train_r   <= train_nxt;
        motor_r   <= motor_nxt;
        merging_r <= merging_nxt;
        cool_r    <= cool_nxt;
        pend_r    <= pend_nxt;
        left_r    <= left_nxt;
        dl_r      <= dl_nxt;
        qend_r    <= qend_nxt;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // The input payload needs no reset; it is only used while iv_r is set.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= in_now_ms;
      bits_r <= in_notify_bits;
      en_r   <= in_enable;
    end
  end

endmodule
